// ===== src/hcbp_pkg.sv =====
// Shared types and constants for the Huffman code bit packer.
// No dependencies; every other file refers to this package by scoped names.
package hcbp_pkg;

   // Item kinds on the request channel
   typedef enum logic [1:0] {
      KIND_LOAD   = 2'd0,
      KIND_ENCODE = 2'd1,
      KIND_FLUSH  = 2'd2
   } kind_type;

   localparam int CODE_W   = 32;  // width of a stored code
   localparam int LEN_W    = 6;   // width of a code length
   localparam int RES_W    = 7;   // residual bits held between items
   localparam int CNT_W    = 3;   // residual bit count
   localparam int WORD_W   = 32;  // up to four packed bytes per item
   localparam int NBYTE_W  = 3;   // 0..4 bytes per item
   localparam int QDEPTH   = 4;   // packed-word queue depth
   localparam int QPTR_W   = 2;
   localparam int QCNT_W   = 3;

   // One code table entry
   typedef struct packed {
      logic [CODE_W-1:0] bits;
      logic [LEN_W-1:0]  len;
   } entry_type;

   // Looked-up item handed from the table stage to the packer
   typedef struct packed {
      logic              valid;
      logic              flush;
      logic [CODE_W-1:0] bits;
      logic [LEN_W-1:0]  len;
   } lookup_type;

   // Packed bytes of one item, earliest byte in the top bits
   typedef struct packed {
      logic [WORD_W-1:0]  data;
      logic [NBYTE_W-1:0] nbytes;
   } word_type;

endpackage

// ===== src/hcbp_table.sv =====
// Code table memory with per-entry valid bits and the input stage register.
// Depends on hcbp_pkg.
module hcbp_table #(
   parameter int MAX_CODE_LEN  = 32,
   parameter int ALPHABET_SIZE = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_take,
   input  logic [1:0]                      in_kind,
   input  logic [7:0]                      in_symbol,
   input  logic [hcbp_pkg::CODE_W-1:0]     in_code_bits,
   input  logic [hcbp_pkg::LEN_W-1:0]      in_code_len,
   input  logic                            go,
   output hcbp_pkg::lookup_type            lookup
);

   localparam int IDX_W   = $clog2(ALPHABET_SIZE);
   localparam int LEN_CAP = (MAX_CODE_LEN < hcbp_pkg::CODE_W) ? MAX_CODE_LEN
                                                               : hcbp_pkg::CODE_W;

   hcbp_pkg::entry_type                code_mem_ff [ALPHABET_SIZE];
   logic [ALPHABET_SIZE-1:0]           valid_ff;
   hcbp_pkg::entry_type                rd_entry_ff;
   logic                               rd_vld_ff;
   logic                               stage_valid_ff;
   logic                               stage_flush_ff;

   logic                               sym_ok;
   logic [IDX_W-1:0]                   idx;
   logic                               is_load;
   logic                               is_encode;
   logic                               is_flush;
   logic [hcbp_pkg::LEN_W-1:0]         cap_len;
   logic [hcbp_pkg::CODE_W:0]          mask_wide;
   hcbp_pkg::entry_type                wr_entry;
   logic                               stage_valid_in;

   // Decode the transaction and build the entry to store
   always_comb begin
      sym_ok    = {1'b0, in_symbol} < 9'(ALPHABET_SIZE);
      idx       = in_symbol[IDX_W-1:0];
      is_load   = 1'b0;
      is_encode = 1'b0;
      is_flush  = 1'b0;
      case (in_kind)
         hcbp_pkg::KIND_LOAD:   is_load   = 1'b1;
         hcbp_pkg::KIND_ENCODE: is_encode = 1'b1;
         hcbp_pkg::KIND_FLUSH:  is_flush  = 1'b1;
         default: ;
      endcase
      cap_len = (in_code_len > hcbp_pkg::LEN_W'(LEN_CAP)) ? hcbp_pkg::LEN_W'(LEN_CAP)
                                                          : in_code_len;
      mask_wide     = ((hcbp_pkg::CODE_W+1)'(1) << cap_len) - (hcbp_pkg::CODE_W+1)'(1);
      wr_entry.bits = in_code_bits & mask_wide[hcbp_pkg::CODE_W-1:0];
      wr_entry.len  = cap_len;
      stage_valid_in = in_take && ((is_encode && sym_ok) || is_flush);
   end

   // Write the memory on a load; read it on every accepted transaction
   always_ff @(posedge clock) begin
      if (in_take && is_load && sym_ok) begin
         code_mem_ff[idx] <= wr_entry;
      end
      if (in_take) begin
         rd_entry_ff <= code_mem_ff[idx];
         rd_vld_ff   <= valid_ff[idx];
      end
   end

   // Mark entries written since reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (in_take && is_load && sym_ok) begin
         valid_ff[idx] <= 1'b1;
      end
   end

   // Advance the stage register when the packer takes its contents
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         stage_flush_ff <= 1'b0;
      end else if (go) begin
         stage_valid_ff <= stage_valid_in;
         stage_flush_ff <= in_take && is_flush;
      end
   end

   // An entry never written reads as having no code
   always_comb begin
      lookup.valid = stage_valid_ff;
      lookup.flush = stage_flush_ff;
      lookup.bits  = rd_vld_ff ? rd_entry_ff.bits : '0;
      lookup.len   = rd_vld_ff ? rd_entry_ff.len  : '0;
   end

   // A transaction is only taken when the stage can advance
   assert property (@(posedge clock) disable iff (reset) in_take |-> go)
      else $error("hcbp_table: transaction taken while stage held");

   // A stored length never exceeds the cap
   assert property (@(posedge clock) disable iff (reset)
      (in_take && is_load && sym_ok) |-> (wr_entry.len <= hcbp_pkg::LEN_W'(LEN_CAP)))
      else $error("hcbp_table: stored length above cap");

   // A held stage keeps its contents
   assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !go) |=> (stage_valid_ff && $stable(rd_entry_ff) && $stable(rd_vld_ff)))
      else $error("hcbp_table: held stage changed");

endmodule

// ===== src/hcbp_pack.sv =====
// Bit packer: appends a looked-up code to the residual bits and splits off whole bytes.
// Depends on hcbp_pkg.
module hcbp_pack (
   input  logic                  clock,
   input  logic                  reset,
   input  hcbp_pkg::lookup_type  lookup,
   input  logic                  q_full,
   output logic                  go,
   output logic                  push,
   output hcbp_pkg::word_type    push_word
);

   logic [hcbp_pkg::RES_W-1:0]  res_ff;
   logic [hcbp_pkg::CNT_W-1:0]  cnt_ff;
   logic [hcbp_pkg::RES_W-1:0]  res_in;
   logic [hcbp_pkg::CNT_W-1:0]  cnt_in;

   logic [hcbp_pkg::LEN_W-1:0]  total;
   logic [38:0]                 acc;
   logic [39:0]                 aligned;
   logic [7:0]                  keep_mask;
   logic [7:0]                  flush_byte;
   hcbp_pkg::word_type          word;

   // Concatenate residual and code, left-align, and cut into bytes; or pad the residual on a flush
   always_comb begin
      total     = lookup.len + hcbp_pkg::LEN_W'(cnt_ff);
      acc       = (39'(res_ff) << lookup.len) | 39'(lookup.bits);
      aligned   = {1'b0, acc} << (6'd40 - total);
      keep_mask = (8'd1 << total[2:0]) - 8'd1;
      flush_byte = 8'({1'b0, res_ff} << (4'd8 - {1'b0, cnt_ff}));

      if (lookup.flush) begin
         word.data   = {flush_byte, 24'd0};
         word.nbytes = (cnt_ff != '0) ? 3'd1 : 3'd0;
         res_in      = '0;
         cnt_in      = '0;
      end else begin
         word.data   = aligned[39:8];
         word.nbytes = total[5:3];
         res_in      = acc[6:0] & keep_mask[6:0];
         cnt_in      = total[2:0];
      end

      go        = !lookup.valid || (word.nbytes == '0) || !q_full;
      push      = lookup.valid && (word.nbytes != '0) && !q_full;
      push_word = word;
   end

   // Update the residual when an item is consumed
   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= '0;
         cnt_ff <= '0;
      end else if (lookup.valid && go) begin
         res_ff <= res_in;
         cnt_ff <= cnt_in;
      end
   end

   // Residual bits above the count stay zero
   assert property (@(posedge clock) disable iff (reset) (res_ff >> cnt_ff) == '0)
      else $error("hcbp_pack: stray residual bits");

   // Never push into a full queue
   assert property (@(posedge clock) disable iff (reset) push |-> !q_full)
      else $error("hcbp_pack: push while queue full");

   // A flush leaves the residual empty
   assert property (@(posedge clock) disable iff (reset)
      (lookup.valid && lookup.flush && go) |=> (cnt_ff == '0))
      else $error("hcbp_pack: residual not cleared by flush");

endmodule

// ===== src/hcbp_out_queue.sv =====
// Packed-word queue and byte serialiser driving the response channel.
// Depends on hcbp_pkg.
module hcbp_out_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hcbp_pkg::word_type  push_word,
   output logic                q_full,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_last_of_run
);

   hcbp_pkg::word_type               word_ff [hcbp_pkg::QDEPTH];
   logic [hcbp_pkg::QPTR_W-1:0]      head_ff;
   logic [hcbp_pkg::QPTR_W-1:0]      tail_ff;
   logic [hcbp_pkg::QCNT_W-1:0]      count_ff;
   logic [1:0]                       idx_ff;

   hcbp_pkg::word_type               head_word;
   logic [4:0]                       sel;
   logic                             take;
   logic                             pop;

   // Select the current byte from the head word
   always_comb begin
      head_word       = word_ff[head_ff];
      sel             = 5'd31 - {idx_ff, 3'b000};
      rsp_valid       = (count_ff != '0);
      rsp_out_byte    = head_word.data[sel -: 8];
      rsp_last_of_run = ({1'b0, idx_ff} == (head_word.nbytes - 3'd1));
      take            = rsp_valid && !rsp_stall;
      pop             = take && rsp_last_of_run;
      q_full          = (count_ff == hcbp_pkg::QCNT_W'(hcbp_pkg::QDEPTH));
   end

   // Store pushed words
   always_ff @(posedge clock) begin
      if (push) begin
         word_ff[tail_ff] <= push_word;
      end
   end

   // Advance pointers, count and byte index
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         if (push) begin
            tail_ff <= tail_ff + hcbp_pkg::QPTR_W'(1);
         end
         if (pop) begin
            head_ff <= head_ff + hcbp_pkg::QPTR_W'(1);
            idx_ff  <= '0;
         end else if (take) begin
            idx_ff  <= idx_ff + 2'd1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + hcbp_pkg::QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - hcbp_pkg::QCNT_W'(1);
         end
      end
   end

   // Occupancy stays within the queue
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= hcbp_pkg::QCNT_W'(hcbp_pkg::QDEPTH))
      else $error("hcbp_out_queue: occupancy overflow");

   // The byte index stays inside the head word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, idx_ff} < head_word.nbytes))
      else $error("hcbp_out_queue: byte index past head word");

   // An empty queue serialises nothing
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (idx_ff == '0))
      else $error("hcbp_out_queue: index moved on empty queue");

endmodule

// ===== src/huffman_code_bit_packer.sv =====
// Huffman code bit packer, top level. A transaction's table entry is read into the stage register
// when accepted; the packer then pushes its bytes into the queue, which offers them. Throughput:
// one transaction per cycle while not stalled; bytes leave one per cycle unless rsp_stall holds
// them, from a four-word queue; requests stall while that queue is full and the staged item has
// bytes to push. Reset (synchronous) clears all 256 table valid bits at once, the residual and
// the queue; there is no clearing pass. Depends on hcbp_pkg, hcbp_table, hcbp_pack, hcbp_out_queue.
module huffman_code_bit_packer #(
   parameter int MAX_CODE_LEN  = 32,
   parameter int ALPHABET_SIZE = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_symbol,
   input  logic [31:0] req_code_bits,
   input  logic [5:0]  req_code_len,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run
);

   hcbp_pkg::lookup_type  lookup;
   hcbp_pkg::word_type    push_word;
   logic                  go;
   logic                  push;
   logic                  q_full;
   logic                  in_take;

   // Hold the request while the stage register cannot advance
   assign req_stall = !go;
   assign in_take   = req_valid && go;

   hcbp_table #(
      .MAX_CODE_LEN  (MAX_CODE_LEN),
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_table (
      .clock        (clock),
      .reset        (reset),
      .in_take      (in_take),
      .in_kind      (req_kind),
      .in_symbol    (req_symbol),
      .in_code_bits (req_code_bits),
      .in_code_len  (req_code_len),
      .go           (go),
      .lookup       (lookup)
   );

   hcbp_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .lookup    (lookup),
      .q_full    (q_full),
      .go        (go),
      .push      (push),
      .push_word (push_word)
   );

   hcbp_out_queue u_out_queue (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .push_word       (push_word),
      .q_full          (q_full),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ===== tb/tb_huffman_code_bit_packer.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for huffman_code_bit_packer: a scoreboard class predicts
// the packed bytes of every accepted transaction and checks each byte that leaves.
// Depends on hcbp_pkg and the huffman_code_bit_packer RTL.
module tb_huffman_code_bit_packer;

   localparam int MAX_CODE_LEN  = 32;
   localparam int ALPHABET_SIZE = 256;
   localparam int LEN_CAP       = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
   localparam int RANDOM_ITEMS  = 100;
   localparam int LONG_HOLD     = 80;
   localparam int CYCLE_LIMIT   = 200000;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // One expected byte on the result channel
   typedef struct packed {
      logic [7:0] octet;
      logic       last_of_run;
   } byte_result_type;

   // Code table and residual buffer kept alongside the block
   class packer_scoreboard;
      logic [31:0]     stored_code [ALPHABET_SIZE];
      logic [5:0]      stored_len [ALPHABET_SIZE];
      logic [6:0]      held_bits;
      logic [2:0]      held_count;
      byte_result_type awaited [$];
      int unsigned     failures;

      function new();
         foreach (stored_len[i]) begin
            stored_code[i] = '0;
            stored_len[i]  = '0;
         end
         held_bits  = '0;
         held_count = '0;
         failures   = 0;
      endfunction

      function int unsigned outstanding();
         return awaited.size();
      endfunction

      // Update the table or buffer and queue the bytes this transaction yields
      function void take_request(logic [1:0] kind, logic [7:0] symbol,
                                 logic [31:0] code_bits, logic [5:0] code_len);
         logic [5:0]      len;
         logic [63:0]     mask;
         logic [63:0]     acc;
         int unsigned     total;
         byte_result_type r;
         case (kind)
            hcbp_pkg::KIND_LOAD: begin
               len  = (code_len > LEN_CAP) ? 6'(LEN_CAP) : code_len;
               mask = (64'd1 << len) - 64'd1;
               stored_code[symbol] = code_bits & mask[31:0];
               stored_len[symbol]  = len;
            end
            hcbp_pkg::KIND_ENCODE: begin
               len = stored_len[symbol];
               if (len != 0) begin
                  acc   = ({57'd0, held_bits} << len) | {32'd0, stored_code[symbol]};
                  total = int'(held_count) + int'(len);
                  // peel off whole bytes, earliest bits first
                  while (total >= 8) begin
                     total -= 8;
                     r.octet       = 8'(acc >> total);
                     r.last_of_run = (total < 8);
                     awaited = {awaited, r};
                  end
                  held_bits  = 7'(acc & ((64'd1 << total) - 64'd1));
                  held_count = 3'(total);
               end
            end
            hcbp_pkg::KIND_FLUSH: begin
               if (held_count != 0) begin
                  r.octet       = 8'({1'b0, held_bits} << (8 - held_count));
                  r.last_of_run = 1'b1;
                  awaited = {awaited, r};
                  held_bits  = '0;
                  held_count = '0;
               end
            end
            default: ;
         endcase
      endfunction

      // Compare one delivered byte with the oldest expectation
      function void check_byte(logic [7:0] octet, logic last_of_run);
         byte_result_type want;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected byte, expected none, actual out_byte %02h last_of_run %0b",
                     $time, octet, last_of_run);
            failures++;
         end else begin
            want = awaited.pop_front();
            if (octet !== want.octet) begin
               $display("%0t: out_byte expected %02h actual %02h", $time, want.octet, octet);
               failures++;
            end
            if (last_of_run !== want.last_of_run) begin
               $display("%0t: last_of_run expected %0b actual %0b",
                        $time, want.last_of_run, last_of_run);
               failures++;
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind = hcbp_pkg::KIND_LOAD;
   logic [7:0]  req_symbol = '0;
   logic [31:0] req_code_bits = '0;
   logic [5:0]  req_code_len = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_of_run;

   packer_scoreboard packer;
   logic [7:0]       loaded_symbols [$];
   bit               quiet = 1'b0;
   bit               hold_rsp = 1'b0;
   int unsigned      sent = 0;
   int unsigned      cycle_count = 0;

   huffman_code_bit_packer #(
      .MAX_CODE_LEN  (MAX_CODE_LEN),
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_symbol      (req_symbol),
      .req_code_bits   (req_code_bits),
      .req_code_len    (req_code_len),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("huffman_code_bit_packer regression: fail");
         $finish;
      end
   end

   // Observe both handshakes at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            packer.take_request(req_kind, req_symbol, req_code_bits, req_code_len);
         if (rsp_valid && !rsp_stall)
            packer.check_byte(rsp_out_byte, rsp_last_of_run);
      end
   end

   // Mostly no gap, some short ones, a few long ones
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 30);
   endfunction

   // Receiver: random stalls, plus one long hold-off on request
   always begin : receiver
      int unsigned n;
      int unsigned held;
      @(negedge clock);
      if (hold_rsp) begin
         rsp_stall <= 1'b1;
         for (held = 0; held < LONG_HOLD; held++)
            @(negedge clock);
         hold_rsp = 1'b0;
         rsp_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
         n = idle_len() + 1;
         rsp_stall <= 1'b1;
         repeat (n) @(negedge clock);
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Offer one transaction and hold it until accepted
   task automatic send_item(logic [1:0] kind, logic [7:0] symbol,
                            logic [31:0] code_bits, logic [5:0] code_len);
      int unsigned gap;
      gap = quiet ? 0 : idle_len();
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_symbol    <= symbol;
      req_code_bits <= code_bits;
      req_code_len  <= code_len;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Drop valid and wait for every expected byte to arrive
   task automatic pause_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (packer.outstanding() != 0)
         @(negedge clock);
   endtask

   function automatic logic [5:0] pick_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 5)
         return 6'd0;
      else if (r < 10)
         return 6'($urandom_range(33, 63));
      else if (r < 25)
         return 6'($urandom_range(13, 32));
      else
         return 6'($urandom_range(1, 12));
   endfunction

   function automatic logic [7:0] pick_loaded();
      if (loaded_symbols.size() == 0 || $urandom_range(0, 9) == 0)
         return 8'($urandom_range(0, 255));
      return loaded_symbols[$urandom_range(0, loaded_symbols.size() - 1)];
   endfunction

   // Extremes, every kind and each corner of the packing
   task automatic directed_items();
      send_item(hcbp_pkg::KIND_ENCODE, 8'h00, $urandom(), 6'($urandom()));  // never loaded
      send_item(hcbp_pkg::KIND_FLUSH, 8'h00, 32'h0, 6'd0);                  // empty buffer
      send_item(KIND_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);                   // ignored kind
      send_item(hcbp_pkg::KIND_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32);
      send_item(hcbp_pkg::KIND_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd1);            // upper bits masked
      send_item(hcbp_pkg::KIND_LOAD, 8'h55, 32'hA5A5_A5A5, 6'h3F);           // length saturates
      send_item(hcbp_pkg::KIND_LOAD, 8'hAA, 32'h0000_0000, 6'd7);
      send_item(hcbp_pkg::KIND_LOAD, 8'h01, 32'h0000_0155, 6'd0);            // zero-length entry
      send_item(hcbp_pkg::KIND_LOAD, 8'h02, 32'h0000_002D, 6'd6);
      send_item(hcbp_pkg::KIND_ENCODE, 8'h00, 32'h0, 6'd0);
      send_item(hcbp_pkg::KIND_ENCODE, 8'hAA, 32'h0, 6'd0);                  // exactly one byte
      send_item(hcbp_pkg::KIND_ENCODE, 8'hFF, 32'h0, 6'd0);                  // four whole bytes
      send_item(hcbp_pkg::KIND_ENCODE, 8'h00, 32'h0, 6'd0);
      send_item(hcbp_pkg::KIND_ENCODE, 8'h55, 32'h0, 6'd0);                  // four bytes plus one bit
      send_item(hcbp_pkg::KIND_ENCODE, 8'h01, 32'h0, 6'd0);                  // emits nothing
      send_item(hcbp_pkg::KIND_ENCODE, 8'h02, 32'h0, 6'd0);                  // seven bits pending
      send_item(hcbp_pkg::KIND_ENCODE, 8'hFF, 32'h0, 6'd0);                  // fullest buffer
      send_item(hcbp_pkg::KIND_FLUSH, 8'h00, 32'h0, 6'd0);
      send_item(hcbp_pkg::KIND_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
      send_item(hcbp_pkg::KIND_ENCODE, 8'h00, 32'h0, 6'd0);
      send_item(hcbp_pkg::KIND_FLUSH, 8'h00, 32'h0, 6'd0);                  // single padded bit
      send_item(hcbp_pkg::KIND_LOAD, 8'h03, 32'h1234_5678, 6'd32);
      send_item(hcbp_pkg::KIND_ENCODE, 8'h03, 32'h0, 6'd0);
      loaded_symbols = '{8'hFF, 8'h00, 8'h55, 8'hAA, 8'h01, 8'h02, 8'h03};
   endtask

   // Loads, a run of encodes, then usually a flush; sprinkle unused kinds as noise
   task automatic random_block();
      int unsigned n_load;
      int unsigned n_enc;
      int unsigned i;
      logic [7:0]  s;
      n_load = $urandom_range(1, 4);
      for (i = 0; i < n_load; i++) begin
         if (loaded_symbols.size() < 24) begin
            s = 8'($urandom_range(0, 255));
            loaded_symbols = {loaded_symbols, s};
         end else begin
            s = pick_loaded();
         end
         send_item(hcbp_pkg::KIND_LOAD, s, $urandom(), pick_len());
         sent++;
      end
      n_enc = $urandom_range(3, 10);
      for (i = 0; i < n_enc; i++) begin
         if ($urandom_range(0, 19) == 0)
            send_item(KIND_UNUSED, 8'($urandom()), $urandom(), 6'($urandom()));
         send_item(hcbp_pkg::KIND_ENCODE, pick_loaded(), $urandom(), 6'($urandom()));
         sent++;
      end
      if ($urandom_range(0, 4) != 0) begin
         send_item(hcbp_pkg::KIND_FLUSH, 8'($urandom()), $urandom(), 6'($urandom()));
         sent++;
      end
   endtask

   // Hold the receiver off while long codes keep arriving, so the queue fills
   task automatic overload_output();
      logic [7:0]  s;
      int unsigned i;
      s = 8'($urandom_range(0, 255));
      quiet = 1'b1;
      send_item(hcbp_pkg::KIND_LOAD, s, $urandom(), 6'd32);
      hold_rsp = 1'b1;
      for (i = 0; i < 12; i++)
         send_item(hcbp_pkg::KIND_ENCODE, s, $urandom(), 6'($urandom()));
      sent += 13;
      pause_until_drained();
      quiet = 1'b0;
   endtask

   initial begin
      bit overloaded;
      overloaded = 1'b0;
      packer = new();
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      directed_items();
      pause_until_drained();

      while (sent < RANDOM_ITEMS) begin
         quiet = ($urandom_range(0, 4) == 0);
         random_block();
         if (!overloaded && sent >= 50) begin
            overload_output();
            overloaded = 1'b1;
         end
         if ($urandom_range(0, 3) == 0)
            pause_until_drained();
      end

      // let the last bytes out and watch for strays
      quiet = 1'b1;
      pause_until_drained();
      repeat (8) @(negedge clock);
      if (packer.failures == 0)
         $display("huffman_code_bit_packer regression: pass");
      else
         $display("huffman_code_bit_packer regression: fail");
      $finish;
   end

endmodule
